@@ rtl/nww_pkg.sv @@
// nww_pkg: shared constants and types of the nearest waypoint window block
// depends on nothing; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package nww_pkg;

    localparam int PATHS      = 8;
    localparam int MAX_POINTS = 1024;
    localparam int WINDOW_MAX = 64;

    localparam int PATH_W  = $clog2(PATHS);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int LEN_W   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W  = PATH_W + IDX_W;
    localparam int WIN_W   = 7;
    localparam int COORD_W = 32;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int WORD_W  = 2 * COORD_W;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(20);
    localparam logic [WIN_W-1:0] WIN_SAT   = WIN_W'(WINDOW_MAX);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [PATH_W-1:0]         path;
        logic [IDX_W-1:0]          index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } nww_item_t;

endpackage

`default_nettype wire

@@ rtl/nww_in_if.sv @@
// nww_in_if, nww_out_if: valid/ready channels of the nearest waypoint window
// depends on nww_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface nww_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic [nww_pkg::PATH_W-1:0]            path_sel;
    logic [nww_pkg::IDX_W-1:0]             point_index;
    logic signed [nww_pkg::COORD_W-1:0]    pos_x;
    logic signed [nww_pkg::COORD_W-1:0]    pos_y;
    logic                                  last_point;

    modport source (output valid, cmd, path_sel, point_index, pos_x, pos_y, last_point,
                    input ready);
    modport sink   (input valid, cmd, path_sel, point_index, pos_x, pos_y, last_point,
                    output ready);
endinterface

interface nww_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [nww_pkg::PATH_W-1:0]            out_path;
    logic [nww_pkg::IDX_W-1:0]             out_index;
    logic signed [nww_pkg::COORD_W-1:0]    out_x;
    logic signed [nww_pkg::COORD_W-1:0]    out_y;
    logic                                  window_end;

    modport source (output valid, out_path, out_index, out_x, out_y, window_end,
                    input ready);
    modport sink   (input valid, out_path, out_index, out_x, out_y, window_end,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/nearest_waypoint_window.sv @@
// nearest_waypoint_window: a write, or a query that emits nothing, is taken in the idle state.
// a query scans its path (one memory read per cycle, 3 distance stages), then passes a
// setup state and emits up to one window item per cycle while the output is not held back;
// the next input is taken only once the last window item has been read from memory.
// reset clears all path lengths and sets the window length to 20; waypoint memory is not cleared.
// depends on nww_pkg and the channel interfaces in nww_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

module nearest_waypoint_window (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [nww_pkg::WIN_W-1:0]     cfg_wdata,
    nww_in_if.sink                             in_item,
    nww_out_if.source                          out_item
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SETUP, ST_EMIT} state_t;

    // waypoint memory: x in the high half, y in the low half
    logic [nww_pkg::WORD_W-1:0] mem [nww_pkg::PATHS*nww_pkg::MAX_POINTS];
    logic [nww_pkg::WORD_W-1:0] mem_rdata_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [nww_pkg::ADDR_W-1:0] mem_waddr;
    logic [nww_pkg::ADDR_W-1:0] mem_raddr;

    state_t state_reg, state_next;
    logic [nww_pkg::WIN_W-1:0] win_len_reg, win_len_next;
    logic [nww_pkg::LEN_W-1:0] path_len_reg [nww_pkg::PATHS];
    logic [nww_pkg::LEN_W-1:0] path_len_next [nww_pkg::PATHS];

    logic [nww_pkg::PATH_W-1:0]         q_sel_reg, q_sel_next;
    logic signed [nww_pkg::COORD_W-1:0] q_px_reg, q_px_next;
    logic signed [nww_pkg::COORD_W-1:0] q_py_reg, q_py_next;
    logic [nww_pkg::LEN_W-1:0]          q_len_reg, q_len_next;
    logic [nww_pkg::WIN_W-1:0]          q_win_reg, q_win_next;
    logic [nww_pkg::IDX_W-1:0]          q_last_reg, q_last_next;

    logic [nww_pkg::LEN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic                      scan_issue;

    // distance pipeline: valid and index tags per stage
    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic [nww_pkg::IDX_W-1:0]  i1_reg, i2_reg, i3_reg, i4_reg;
    logic [nww_pkg::COORD_W-1:0] mag_x_reg, mag_y_reg;
    logic [nww_pkg::SQ_W-1:0]   sq_x_reg, sq_y_reg;
    logic [nww_pkg::DIST_W-1:0] dist_reg;

    logic [nww_pkg::DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [nww_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;

    logic [nww_pkg::WIN_W-1:0]  emit_left_reg, emit_left_next;
    logic [nww_pkg::IDX_W-1:0]  emit_idx_reg, emit_idx_next;
    logic                       emit_issue;

    logic                       rd_pend_reg, rd_pend_next;
    logic [nww_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic                       rd_end_reg, rd_end_next;

    logic                       out_v_reg, out_v_next;
    nww_pkg::nww_item_t         out_reg, out_next;
    logic                       skid_v_reg, skid_v_next;
    nww_pkg::nww_item_t         skid_reg, skid_next;
    nww_pkg::nww_item_t         arrive;

    logic                       in_acc;
    logic                       out_free;
    logic [1:0]                 occ_after;
    logic [nww_pkg::WIN_W-1:0]  win_sat;
    logic [nww_pkg::LEN_W-1:0]  sel_len;
    logic [nww_pkg::LEN_W-1:0]  remain;
    logic [nww_pkg::LEN_W-1:0]  len_m1;

    logic signed [nww_pkg::COORD_W:0] dx, dy;
    logic [nww_pkg::COORD_W:0]        ax, ay;

    assign in_item.ready = (state_reg == ST_IDLE);
    assign in_acc        = in_item.valid && in_item.ready;

    assign out_item.valid      = out_v_reg;
    assign out_item.out_path   = out_reg.path;
    assign out_item.out_index  = out_reg.index;
    assign out_item.out_x      = out_reg.x;
    assign out_item.out_y      = out_reg.y;
    assign out_item.window_end = out_reg.last;

    assign win_sat = (win_len_reg > nww_pkg::WIN_SAT) ? nww_pkg::WIN_SAT : win_len_reg;
    assign sel_len = path_len_reg[in_item.path_sel];
    assign len_m1  = sel_len - nww_pkg::LEN_W'(1);

    assign scan_issue = (state_reg == ST_SCAN) && (scan_cnt_reg < q_len_reg);

    // slots still held after this cycle: pending read, skid, undelivered output
    assign out_free  = !out_v_reg || out_item.ready;
    assign occ_after = 2'(rd_pend_reg) + 2'(skid_v_reg) + 2'(!out_free);
    assign emit_issue = (state_reg == ST_EMIT) && (emit_left_reg != '0) && (occ_after < 2'd2);

    assign mem_we    = in_acc && (in_item.cmd == nww_pkg::CMD_WRITE);
    assign mem_waddr = {in_item.path_sel, in_item.point_index};
    assign mem_re    = scan_issue || emit_issue;
    assign mem_raddr = scan_issue ? {q_sel_reg, scan_cnt_reg[nww_pkg::IDX_W-1:0]}
                                  : {q_sel_reg, emit_idx_reg};

    assign arrive.path  = q_sel_reg;
    assign arrive.index = rd_idx_reg;
    assign arrive.x     = mem_rdata_reg[nww_pkg::WORD_W-1:nww_pkg::COORD_W];
    assign arrive.y     = mem_rdata_reg[nww_pkg::COORD_W-1:0];
    assign arrive.last  = rd_end_reg;

    assign remain = q_len_reg - nww_pkg::LEN_W'(best_idx_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {in_item.pos_x, in_item.pos_y};
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // stage 1: absolute values of the 33-bit signed coordinate differences
    always_comb
    begin
        dx = {q_px_reg[nww_pkg::COORD_W-1], q_px_reg}
           - {mem_rdata_reg[nww_pkg::WORD_W-1], mem_rdata_reg[nww_pkg::WORD_W-1:nww_pkg::COORD_W]};
        dy = {q_py_reg[nww_pkg::COORD_W-1], q_py_reg}
           - {mem_rdata_reg[nww_pkg::COORD_W-1], mem_rdata_reg[nww_pkg::COORD_W-1:0]};
        ax = dx[nww_pkg::COORD_W] ? 33'(-dx) : 33'(dx);
        ay = dy[nww_pkg::COORD_W] ? 33'(-dy) : 33'(dy);
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg <= ax[nww_pkg::COORD_W-1:0];
        mag_y_reg <= ay[nww_pkg::COORD_W-1:0];
        i2_reg    <= i1_reg;
        sq_x_reg  <= nww_pkg::SQ_W'(mag_x_reg) * nww_pkg::SQ_W'(mag_x_reg);
        sq_y_reg  <= nww_pkg::SQ_W'(mag_y_reg) * nww_pkg::SQ_W'(mag_y_reg);
        i3_reg    <= i2_reg;
        dist_reg  <= {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        i4_reg    <= i3_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        win_len_next   = cfg_we ? cfg_wdata : win_len_reg;
        path_len_next  = path_len_reg;
        q_sel_next     = q_sel_reg;
        q_px_next      = q_px_reg;
        q_py_next      = q_py_reg;
        q_len_next     = q_len_reg;
        q_win_next     = q_win_reg;
        q_last_next    = q_last_reg;
        scan_cnt_next  = scan_cnt_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        emit_left_next = emit_left_reg;
        emit_idx_next  = emit_idx_reg;
        rd_pend_next   = emit_issue;
        rd_idx_next    = emit_issue ? emit_idx_reg : rd_idx_reg;
        rd_end_next    = emit_issue ? (emit_left_reg == nww_pkg::WIN_W'(1)) : rd_end_reg;
        out_v_next     = out_v_reg;
        out_next       = out_reg;
        skid_v_next    = skid_v_reg;
        skid_next      = skid_reg;

        // output register with one skid slot behind it
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_next  = 1'b1;
                out_next    = skid_reg;
                skid_v_next = rd_pend_reg;
                skid_next   = arrive;
            end
            else
            begin
                out_v_next = rd_pend_reg;
                out_next   = arrive;
            end
        end
        else if (rd_pend_reg)
        begin
            skid_v_next = 1'b1;
            skid_next   = arrive;
        end

        // nearest point, lowest index wins a tie
        if (v4_reg && ((i4_reg == '0) || (dist_reg < best_dist_reg)))
        begin
            best_dist_next = dist_reg;
            best_idx_next  = i4_reg;
        end

        if (scan_issue)
        begin
            scan_cnt_next = scan_cnt_reg + nww_pkg::LEN_W'(1);
        end

        if (emit_issue)
        begin
            emit_idx_next  = emit_idx_reg + nww_pkg::IDX_W'(1);
            emit_left_next = emit_left_reg - nww_pkg::WIN_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_item.cmd == nww_pkg::CMD_WRITE)
                    begin
                        if (in_item.last_point)
                        begin
                            path_len_next[in_item.path_sel] =
                                nww_pkg::LEN_W'(in_item.point_index) + nww_pkg::LEN_W'(1);
                        end
                    end
                    else if ((sel_len != '0) && (win_sat != '0))
                    begin
                        q_sel_next    = in_item.path_sel;
                        q_px_next     = in_item.pos_x;
                        q_py_next     = in_item.pos_y;
                        q_len_next    = sel_len;
                        q_win_next    = win_sat;
                        q_last_next   = len_m1[nww_pkg::IDX_W-1:0];
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (v4_reg && (i4_reg == q_last_reg))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                emit_idx_next  = best_idx_reg;
                emit_left_next = (remain > nww_pkg::LEN_W'(q_win_reg))
                               ? q_win_reg : remain[nww_pkg::WIN_W-1:0];
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if ((emit_left_reg == '0) && !rd_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_len_reg   <= nww_pkg::WIN_RESET;
            for (int p = 0; p < nww_pkg::PATHS; p++)
            begin
                path_len_reg[p] <= '0;
            end
            q_sel_reg     <= '0;
            q_px_reg      <= '0;
            q_py_reg      <= '0;
            q_len_reg     <= '0;
            q_win_reg     <= '0;
            q_last_reg    <= '0;
            scan_cnt_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            i1_reg        <= '0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            emit_left_reg <= '0;
            emit_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            rd_end_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
            out_reg       <= '0;
            skid_v_reg    <= 1'b0;
            skid_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            win_len_reg   <= win_len_next;
            path_len_reg  <= path_len_next;
            q_sel_reg     <= q_sel_next;
            q_px_reg      <= q_px_next;
            q_py_reg      <= q_py_next;
            q_len_reg     <= q_len_next;
            q_win_reg     <= q_win_next;
            q_last_reg    <= q_last_next;
            scan_cnt_reg  <= scan_cnt_next;
            v1_reg        <= scan_issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            i1_reg        <= scan_cnt_reg[nww_pkg::IDX_W-1:0];
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            emit_left_reg <= emit_left_next;
            emit_idx_reg  <= emit_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            rd_end_reg    <= rd_end_next;
            out_v_reg     <= out_v_next;
            out_reg       <= out_next;
            skid_v_reg    <= skid_v_next;
            skid_reg      <= skid_next;
        end
    end

`ifndef SYNTHESIS
    // the skid slot only fills behind a held output
    assert property (@(posedge clk) disable iff (!rst_n) skid_v_reg |-> out_v_reg)
        else $error("skid item without output item");

    // never more than two window items in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_pend_reg && skid_v_reg && out_v_reg))
        else $error("emit occupancy overflow");

    // scan tags stay inside the queried path
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (nww_pkg::LEN_W'(i4_reg) < q_len_reg))
        else $error("scan index beyond path length");

    // no window read outstanding once the block takes items again
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !rd_pend_reg)
        else $error("window read pending while idle");
`endif

endmodule

`default_nettype wire
